@@ sv/hrbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrbp_pkg
// Shared types and constants for the request head byte parser.
// ----------------------------------------------------------------------------
package hrbp_pkg;

   typedef enum logic [19:0] {
      ST_START      = 20'h00001,
      ST_START_LF   = 20'h00002,
      ST_METHOD     = 20'h00004,
      ST_URI        = 20'h00008,
      ST_H          = 20'h00010,
      ST_HT         = 20'h00020,
      ST_HTT        = 20'h00040,
      ST_HTTP       = 20'h00080,
      ST_SLASH      = 20'h00100,
      ST_MAJOR      = 20'h00200,
      ST_DOT        = 20'h00400,
      ST_MINOR      = 20'h00800,
      ST_LINE_CR    = 20'h01000,
      ST_LINE_LF    = 20'h02000,
      ST_NAME_START = 20'h04000,
      ST_NAME       = 20'h08000,
      ST_VALUE      = 20'h10000,
      ST_HDR_LF     = 20'h20000,
      ST_HDR_LWS    = 20'h40000,
      ST_HDR_END    = 20'h80000
   } state_type;

   localparam logic [1:0] STAT_PROGRESS = 2'd0;
   localparam logic [1:0] STAT_ACCEPT   = 2'd1;
   localparam logic [1:0] STAT_REJECT   = 2'd2;

   localparam logic [2:0] ROLE_NONE   = 3'd0;
   localparam logic [2:0] ROLE_METHOD = 3'd1;
   localparam logic [2:0] ROLE_URI    = 3'd2;
   localparam logic [2:0] ROLE_NAME   = 3'd3;
   localparam logic [2:0] ROLE_VALUE  = 3'd4;
   localparam logic [2:0] ROLE_MAJOR  = 3'd5;
   localparam logic [2:0] ROLE_MINOR  = 3'd6;

   localparam logic [7:0] CH_HT    = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SP    = 8'd32;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_CTL_HI = 8'd31;
   localparam logic [7:0] CH_UPPER_H = 8'h48;
   localparam logic [7:0] CH_UPPER_T = 8'h54;
   localparam logic [7:0] CH_UPPER_P = 8'h50;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic ctl;
      logic token;
      logic uri;
      logic digit;
      logic cr;
      logic lf;
      logic sp;
      logic ht;
   } char_class_type;

   typedef struct packed {
      logic [1:0] parse_status;
      logic [2:0] byte_role;
      logic       header_begins;
      logic [7:0] byte_value;
   } result_type;

endpackage

@@ sv/hrbp_classify.sv @@
// ----------------------------------------------------------------------------
// hrbp_classify
// Sorts one byte into the character classes the parser tests against.
// ----------------------------------------------------------------------------
module hrbp_classify
   import hrbp_pkg::*;
(
   input  logic [7:0]     data_byte,
   output char_class_type cls
);

   logic is_sep;
   logic is_uri_mark;

   always_comb begin
      is_sep = data_byte inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B,
                                 8'h3A, 8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F,
                                 8'h3D, 8'h7B, 8'h7D, CH_SP, CH_HT};
      is_uri_mark = data_byte inside {8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D,
                                      8'h2B, 8'h24, 8'h2C, 8'h2D, 8'h5F, 8'h2E, 8'h21,
                                      8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h25};
      cls.ctl   = (data_byte <= CH_CTL_HI) || (data_byte == CH_DEL);
      cls.token = (data_byte > CH_SP) && (data_byte < CH_DEL) && !is_sep;
      cls.digit = data_byte inside {[CH_ZERO:CH_NINE]};
      cls.uri   = (data_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [CH_ZERO:CH_NINE]})
                  || is_uri_mark;
      cls.cr    = (data_byte == CH_CR);
      cls.lf    = (data_byte == CH_LF);
      cls.sp    = (data_byte == CH_SP);
      cls.ht    = (data_byte == CH_HT);
   end

endmodule

@@ sv/hrbp_fsm.sv @@
// ----------------------------------------------------------------------------
// hrbp_fsm
// Parser state register and the single-pass next state and result logic.
// ----------------------------------------------------------------------------
module hrbp_fsm
   import hrbp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic [7:0]     data_byte,
   input  char_class_type cls,
   output result_type     result
);

   state_type state_ff;
   state_type state_in;
   state_type next_state;
   logic       ok;
   logic [1:0] stat;
   logic [2:0] role;
   logic       begins;
   logic [7:0] val;

   always_comb begin
      next_state = state_ff;
      ok     = 1'b0;
      stat   = STAT_PROGRESS;
      role   = ROLE_NONE;
      begins = 1'b0;
      val    = data_byte;
      case (state_ff)
         ST_START: begin
            if (cls.cr) begin
               next_state = ST_START_LF;
               ok = 1'b1;
            end else if (cls.token) begin
               next_state = ST_METHOD;
               role = ROLE_METHOD;
               ok = 1'b1;
            end
         end
         ST_START_LF: begin
            if (cls.lf) begin
               next_state = ST_START;
               ok = 1'b1;
            end
         end
         ST_METHOD: begin
            if (cls.token) begin
               role = ROLE_METHOD;
               ok = 1'b1;
            end else if (cls.sp) begin
               next_state = ST_URI;
               ok = 1'b1;
            end
         end
         ST_URI: begin
            if (cls.uri) begin
               role = ROLE_URI;
               ok = 1'b1;
            end else if (cls.sp) begin
               next_state = ST_H;
               ok = 1'b1;
            end
         end
         ST_H: begin
            if (data_byte == CH_UPPER_H) begin
               next_state = ST_HT;
               ok = 1'b1;
            end
         end
         ST_HT: begin
            if (data_byte == CH_UPPER_T) begin
               next_state = ST_HTT;
               ok = 1'b1;
            end
         end
         ST_HTT: begin
            if (data_byte == CH_UPPER_T) begin
               next_state = ST_HTTP;
               ok = 1'b1;
            end
         end
         ST_HTTP: begin
            if (data_byte == CH_UPPER_P) begin
               next_state = ST_SLASH;
               ok = 1'b1;
            end
         end
         ST_SLASH: begin
            if (data_byte == CH_SLASH) begin
               next_state = ST_MAJOR;
               ok = 1'b1;
            end
         end
         ST_MAJOR: begin
            if (cls.digit) begin
               next_state = ST_DOT;
               role = ROLE_MAJOR;
               val = data_byte - CH_ZERO;
               ok = 1'b1;
            end
         end
         ST_DOT: begin
            if (data_byte == CH_DOT) begin
               next_state = ST_MINOR;
               ok = 1'b1;
            end
         end
         ST_MINOR: begin
            if (cls.digit) begin
               next_state = ST_LINE_CR;
               role = ROLE_MINOR;
               val = data_byte - CH_ZERO;
               ok = 1'b1;
            end
         end
         ST_LINE_CR: begin
            if (cls.cr) begin
               next_state = ST_LINE_LF;
               ok = 1'b1;
            end
         end
         ST_LINE_LF: begin
            if (cls.lf) begin
               next_state = ST_NAME_START;
               ok = 1'b1;
            end
         end
         ST_NAME_START: begin
            if (cls.cr) begin
               next_state = ST_HDR_END;
               ok = 1'b1;
            end else if (cls.token) begin
               next_state = ST_NAME;
               role = ROLE_NAME;
               begins = 1'b1;
               ok = 1'b1;
            end
         end
         ST_NAME: begin
            if (cls.token) begin
               role = ROLE_NAME;
               ok = 1'b1;
            end else if (data_byte == CH_COLON) begin
               next_state = ST_VALUE;
               ok = 1'b1;
            end
         end
         ST_VALUE: begin
            if (cls.sp || cls.ht) begin
               ok = 1'b1;
            end else if (cls.cr) begin
               next_state = ST_HDR_LF;
               ok = 1'b1;
            end else if (!cls.ctl) begin
               role = ROLE_VALUE;
               ok = 1'b1;
            end
         end
         ST_HDR_LF: begin
            if (cls.lf) begin
               next_state = ST_HDR_LWS;
               ok = 1'b1;
            end
         end
         ST_HDR_LWS: begin
            if (cls.sp || cls.ht) begin
               next_state = ST_VALUE;
               ok = 1'b1;
            end else if (cls.cr) begin
               next_state = ST_HDR_END;
               ok = 1'b1;
            end else if (cls.token) begin
               next_state = ST_NAME;
               role = ROLE_NAME;
               begins = 1'b1;
               ok = 1'b1;
            end
         end
         ST_HDR_END: begin
            if (cls.lf) begin
               stat = STAT_ACCEPT;
               ok = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      // rejected byte leaves the state alone
      if (!ok) begin
         next_state = state_ff;
         stat   = STAT_REJECT;
         role   = ROLE_NONE;
         begins = 1'b0;
         val    = data_byte;
      end
   end

   assign result.parse_status  = stat;
   assign result.byte_role     = role;
   assign result.header_begins = begins;
   assign result.byte_value    = val;

   assign state_in = step_en ? next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_reject_holds_state: assert property (@(posedge clock) disable iff (reset)
      (step_en && stat == STAT_REJECT) |=> $stable(state_ff))
      else $error("state moved on a rejected byte");

   a_accept_at_end: assert property (@(posedge clock) disable iff (reset)
      (step_en && stat == STAT_ACCEPT) |=> (state_ff == ST_HDR_END))
      else $error("accept outside header end");

   a_begins_is_name: assert property (@(posedge clock) disable iff (reset)
      begins |-> (role == ROLE_NAME && (state_ff == ST_NAME_START
                  || state_ff == ST_HDR_LWS)))
      else $error("header start flag on a non-name byte");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (role == ROLE_MAJOR || role == ROLE_MINOR) |-> (val <= 8'd9))
      else $error("version digit out of range");
`endif

endmodule

@@ sv/http_request_byte_parser.sv @@
// ----------------------------------------------------------------------------
// http_request_byte_parser
// Byte-wide HTTP/1.x request head parser with a registered result channel.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and returns one result per byte, in order: the
// parse status, the role of the byte, a header start flag and the byte (or the
// version digit value). A byte is accepted every cycle while the result side
// does not stall; a result passes through the input register and then the
// result register, with the parser state updated in the same pass that forms
// the result. Stall on the result side backs up through both registers.
module http_request_byte_parser
   import hrbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_parse_status,
   output logic [2:0] rsp_byte_role,
   output logic       rsp_header_begins,
   output logic [7:0] rsp_byte_value
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   result_type     rsp_result_ff;
   result_type     step_result;
   char_class_type cls;
   logic           out_free;
   logic           advance;
   logic           take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   hrbp_classify u_classify (
      .data_byte (in_byte_ff),
      .cls       (cls)
   );

   hrbp_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .cls       (cls),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_parse_status  = rsp_result_ff.parse_status;
   assign rsp_byte_role     = rsp_result_ff.byte_role;
   assign rsp_header_begins = rsp_result_ff.header_begins;
   assign rsp_byte_value    = rsp_result_ff.byte_value;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_result_ff)))
      else $error("stalled result overwritten");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte lost");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result transfer dropped");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the request head byte parser.
// ----------------------------------------------------------------------------
// One request head is walked from the start state to acceptance, since the
// parser never leaves its final state. A short directed opening passes through
// the request line with a rejected byte at several states, then a long random
// stretch of header lines follows: names, values with high bytes, folded lines
// and stray bytes. The head is closed with an empty line, and trailing bytes
// probe the state after acceptance. Each result is compared with a
// transfer-by-transfer prediction. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
   import hrbp_pkg::*;

   class parse_tracker;
      state_type  walk_state;
      result_type byte_verdicts [$];
      int         errors;
      int         bytes_seen;
      int         rejects;
      int         accepts;
      int         headers;

      function new();
         walk_state = ST_START;
      endfunction

      static function bit is_ctl(logic [7:0] c);
         return c <= CH_CTL_HI || c == CH_DEL;
      endfunction

      static function bit is_sep(logic [7:0] c);
         case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
            "=", "{", "}", CH_SP, CH_HT: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      static function bit token_char(logic [7:0] c);
         return c <= CH_DEL && !is_ctl(c) && !is_sep(c);
      endfunction

      static function bit digit_char(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      static function bit is_uri(logic [7:0] c);
         if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || digit_char(c))
            return 1'b1;
         case (c)
            ";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "-", "_", ".", "!",
            "~", "*", "'", "(", ")", "%": return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function result_type judge_byte(logic [7:0] c);
         result_type r;
         state_type  nx;
         bit         ok;
         r.parse_status  = STAT_PROGRESS;
         r.byte_role     = ROLE_NONE;
         r.header_begins = 1'b0;
         r.byte_value    = c;
         nx = walk_state;
         ok = 1'b0;
         case (walk_state)
            ST_START: begin
               if (c == CH_CR) begin
                  nx = ST_START_LF; ok = 1'b1;
               end else if (token_char(c)) begin
                  nx = ST_METHOD; r.byte_role = ROLE_METHOD; ok = 1'b1;
               end
            end
            ST_START_LF: if (c == CH_LF) begin nx = ST_START; ok = 1'b1; end
            ST_METHOD: begin
               if (token_char(c)) begin
                  r.byte_role = ROLE_METHOD; ok = 1'b1;
               end else if (c == CH_SP) begin
                  nx = ST_URI; ok = 1'b1;
               end
            end
            ST_URI: begin
               if (is_uri(c)) begin
                  r.byte_role = ROLE_URI; ok = 1'b1;
               end else if (c == CH_SP) begin
                  nx = ST_H; ok = 1'b1;
               end
            end
            ST_H:     if (c == CH_UPPER_H) begin nx = ST_HT; ok = 1'b1; end
            ST_HT:    if (c == CH_UPPER_T) begin nx = ST_HTT; ok = 1'b1; end
            ST_HTT:   if (c == CH_UPPER_T) begin nx = ST_HTTP; ok = 1'b1; end
            ST_HTTP:  if (c == CH_UPPER_P) begin nx = ST_SLASH; ok = 1'b1; end
            ST_SLASH: if (c == CH_SLASH) begin nx = ST_MAJOR; ok = 1'b1; end
            ST_MAJOR: begin
               if (digit_char(c)) begin
                  nx = ST_DOT; r.byte_role = ROLE_MAJOR; r.byte_value = c - CH_ZERO;
                  ok = 1'b1;
               end
            end
            ST_DOT:   if (c == CH_DOT) begin nx = ST_MINOR; ok = 1'b1; end
            ST_MINOR: begin
               if (digit_char(c)) begin
                  nx = ST_LINE_CR; r.byte_role = ROLE_MINOR; r.byte_value = c - CH_ZERO;
                  ok = 1'b1;
               end
            end
            ST_LINE_CR: if (c == CH_CR) begin nx = ST_LINE_LF; ok = 1'b1; end
            ST_LINE_LF: if (c == CH_LF) begin nx = ST_NAME_START; ok = 1'b1; end
            ST_NAME_START: begin
               if (c == CH_CR) begin
                  nx = ST_HDR_END; ok = 1'b1;
               end else if (token_char(c)) begin
                  nx = ST_NAME; r.byte_role = ROLE_NAME; r.header_begins = 1'b1;
                  ok = 1'b1;
               end
            end
            ST_NAME: begin
               if (token_char(c)) begin
                  r.byte_role = ROLE_NAME; ok = 1'b1;
               end else if (c == CH_COLON) begin
                  nx = ST_VALUE; ok = 1'b1;
               end
            end
            ST_VALUE: begin
               if (c == CH_SP || c == CH_HT) begin
                  ok = 1'b1;
               end else if (c == CH_CR) begin
                  nx = ST_HDR_LF; ok = 1'b1;
               end else if (!is_ctl(c)) begin
                  r.byte_role = ROLE_VALUE; ok = 1'b1;
               end
            end
            ST_HDR_LF: if (c == CH_LF) begin nx = ST_HDR_LWS; ok = 1'b1; end
            ST_HDR_LWS: begin
               if (c == CH_SP || c == CH_HT) begin
                  nx = ST_VALUE; ok = 1'b1;
               end else if (c == CH_CR) begin
                  nx = ST_HDR_END; ok = 1'b1;
               end else if (token_char(c)) begin
                  nx = ST_NAME; r.byte_role = ROLE_NAME; r.header_begins = 1'b1;
                  ok = 1'b1;
               end
            end
            ST_HDR_END: begin
               if (c == CH_LF) begin
                  r.parse_status = STAT_ACCEPT; ok = 1'b1;
               end
            end
            default: ok = 1'b0;
         endcase
         if (!ok) begin
            r.parse_status  = STAT_REJECT;
            r.byte_role     = ROLE_NONE;
            r.header_begins = 1'b0;
            r.byte_value    = c;
         end else begin
            walk_state = nx;
         end
         return r;
      endfunction

      function void take_byte(logic [7:0] c);
         result_type r;
         r = judge_byte(c);
         bytes_seen++;
         if (r.parse_status == STAT_REJECT) rejects++;
         if (r.parse_status == STAT_ACCEPT) accepts++;
         if (r.header_begins) headers++;
         byte_verdicts = {byte_verdicts, r};
      endfunction

      function void match_result(logic [1:0] st, logic [2:0] role, logic hb, logic [7:0] val);
         result_type want;
         if (byte_verdicts.size() == 0) begin
            $error("result transfer with nothing outstanding");
            errors++;
            return;
         end
         want = byte_verdicts.pop_front();
         if (st !== want.parse_status) begin
            $error("parse_status: expected %0d, actual %0d", want.parse_status, st);
            errors++;
         end
         if (role !== want.byte_role) begin
            $error("byte_role: expected %0d, actual %0d", want.byte_role, role);
            errors++;
         end
         if (hb !== want.header_begins) begin
            $error("header_begins: expected %0d, actual %0d", want.header_begins, hb);
            errors++;
         end
         if (val !== want.byte_value) begin
            $error("byte_value: expected %0d, actual %0d", want.byte_value, val);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_parse_status;
   logic [2:0] rsp_byte_role;
   logic       rsp_header_begins;
   logic [7:0] rsp_byte_value;

   parse_tracker tracker;
   bit idle_on  = 1'b1;
   bit stall_on = 1'b1;
   int stall_left = 0;

   http_request_byte_parser i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_parse_status  (rsp_parse_status),
      .rsp_byte_role     (rsp_byte_role),
      .rsp_header_begins (rsp_header_begins),
      .rsp_byte_value    (rsp_byte_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_result(rsp_parse_status, rsp_byte_role, rsp_header_begins,
                              rsp_byte_value);
   end

   function automatic logic [7:0] any_token();
      logic [7:0] b;
      do b = 8'($urandom_range(33, 126)); while (!parse_tracker::token_char(b));
      return b;
   endfunction

   function automatic logic [7:0] any_uri();
      logic [7:0] b;
      do b = 8'($urandom_range(33, 126)); while (!parse_tracker::is_uri(b));
      return b;
   endfunction

   // next byte for the given state; closing steers straight to the empty line
   function automatic logic [7:0] next_byte(state_type s, bit closing);
      logic [7:0] b;
      int         pick;
      pick = $urandom_range(0, 9);
      if (!closing && $urandom_range(0, 7) == 0) begin
         b = 8'($urandom_range(0, 255));
         // keep stray bytes from ending the head early
         if ((s == ST_NAME_START || s == ST_HDR_LWS) && b == CH_CR) b = 8'h00;
         return b;
      end
      case (s)
         ST_START:      b = (!closing && pick < 3) ? CH_CR : any_token();
         ST_START_LF:   b = CH_LF;
         ST_METHOD:     b = (closing || pick < 2) ? CH_SP : any_token();
         ST_URI:        b = (closing || pick < 1) ? CH_SP : any_uri();
         ST_H:          b = CH_UPPER_H;
         ST_HT, ST_HTT: b = CH_UPPER_T;
         ST_HTTP:       b = CH_UPPER_P;
         ST_SLASH:      b = CH_SLASH;
         ST_DOT:        b = CH_DOT;
         ST_MAJOR, ST_MINOR: b = CH_ZERO + 8'($urandom_range(0, 9));
         ST_LINE_CR:    b = CH_CR;
         ST_LINE_LF, ST_HDR_LF, ST_HDR_END: b = CH_LF;
         ST_NAME_START: b = closing ? CH_CR : any_token();
         ST_NAME:       b = (closing || pick < 2) ? CH_COLON : any_token();
         ST_VALUE: begin
            if (closing || pick == 0) b = CH_CR;
            else if (pick == 1) b = CH_SP;
            else if (pick == 2) b = CH_HT;
            else do b = 8'($urandom_range(33, 255)); while (b == CH_DEL);
         end
         ST_HDR_LWS: begin
            if (closing) b = CH_CR;
            else if (pick < 2) b = (pick == 0) ? CH_SP : CH_HT;
            else b = any_token();
         end
         default:       b = 8'($urandom_range(0, 255));
      endcase
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_byte(b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.byte_verdicts.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [7:0] opening [$];
      int         n;
      tracker = new();
      // request line with a rejected byte at several states, then a folded header
      opening = '{8'h00, CH_CR, "A", CH_LF, "G", 8'h01, CH_SP, "/", "#", CH_SP,
                  CH_UPPER_H, CH_UPPER_T, CH_UPPER_T, CH_UPPER_P, CH_SLASH, "9", CH_DOT,
                  "0", CH_CR, CH_LF, CH_COLON, "A", CH_COLON, 8'hFF, CH_SP, CH_HT,
                  CH_DEL, CH_CR, CH_LF, CH_HT, "z"};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (opening[i]) send_byte(opening[i]);
      for (n = 0; n < 850; n++) begin
         if (n % 60 == 0) begin
            idle_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
         end
         if (n >= 700) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
         end
         if (n == 400) drain();
         send_byte(next_byte(tracker.walk_state, 1'b0));
      end
      while (tracker.walk_state != ST_HDR_END)
         send_byte(next_byte(tracker.walk_state, 1'b1));
      send_byte(CH_LF);
      repeat (16) send_byte(($urandom_range(0, 1) != 0) ? CH_LF : 8'($urandom_range(0, 255)));
      drain();
      repeat (8) @(posedge clock);
      $display("tb_top: %0d bytes checked, %0d rejected, %0d accepting, %0d header names",
               tracker.bytes_seen, tracker.rejects, tracker.accepts, tracker.headers);
      if (tracker.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
